@@ sv/plru_pkg.sv @@
// shared types, constants and table port structs for the pinned lru policy unit
package plru_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int PIN_W       = 16;
	localparam int SIZE_W      = 32;
	localparam int BYTES_W     = 38;
	localparam int BYTES_OUT_W = 37;
	localparam int MAXE_W      = 16;
	localparam int CMD_W       = 2;
	localparam int KIND_W      = 3;

	localparam logic [MAXE_W-1:0]      MAX_ENTRIES_RST = MAXE_W'(10000);
	localparam logic [BYTES_OUT_W-1:0] MAX_BYTES_RST   = BYTES_OUT_W'(500000000);
	localparam logic [PIN_W-1:0]       PIN_MAX         = {PIN_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic CFG_MAX_ENTRIES = 1'b0;
	localparam logic CFG_MAX_BYTES   = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_HIT      = 3'd0,
		KIND_MISS     = 3'd1,
		KIND_PINNED   = 3'd2,
		KIND_RELEASED = 3'd3,
		KIND_EVICTED  = 3'd4,
		KIND_CLEARED  = 3'd5,
		KIND_ERROR    = 3'd6
	} kind_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic              res_we;
		logic [IDX_W-1:0]  res_addr;
		logic              res_d;
		logic              pin_we;
		logic [IDX_W-1:0]  pin_addr;
		logic [PIN_W-1:0]  pin_d;
		logic              size_we;
		logic [IDX_W-1:0]  size_addr;
		logic [SIZE_W-1:0] size_d;
		logic              onl_we;
		logic [IDX_W-1:0]  onl_addr;
		logic              onl_d;
		logic              newer_we;
		logic [IDX_W-1:0]  newer_addr;
		logic [IDX_W-1:0]  newer_d;
		logic              older_we;
		logic [IDX_W-1:0]  older_addr;
		logic [IDX_W-1:0]  older_d;
	} tbl_wr_t;

	typedef struct packed {
		logic              resident;
		logic [PIN_W-1:0]  pins;
		logic [SIZE_W-1:0] size;
		logic              on_list;
		logic [IDX_W-1:0]  newer;
		logic [IDX_W-1:0]  older;
	} tbl_rd_t;

endpackage

@@ sv/pinned_lru_cache_policy_unit.sv @@
// top level: command sequencer, release list control and result word register
//
// usage
//   command channel: present command, entry_index and entry_bytes with start high;
//   the word is taken at a clock edge where start is high and busy is low. busy
//   stays high until every result word of that command has been issued.
//   result channel: each result word sits on kind, result_index, pin_count,
//   entries_resident, bytes_resident and last for exactly one cycle, marked by
//   result_valid; the receiver cannot stall it, so it must take every word.
//   last marks the final word of a command.
//   config channel: cfg_index 0 writes max_entries, 1 writes max_bytes; a write
//   is taken when cfg_valid and cfg_ready are high, cfg_ready is high when idle.
// sequencing
//   hit, still pinned, error: decode, then limit check, which issues the only word.
//   miss or release with k evictions: decode and check, then per eviction a drop
//   and a limit check on the shared adder, each check issuing one word.
//   clear of k entries: decode, then one dropped entry and one word per cycle.
//   this sequencing follows from the single entry-table read port and the one
//   38-bit adder shared by byte accounting and the byte-limit compare.
// reset
//   no entry resident, release list empty, limits back to 10000 entries and
//   500000000 bytes; no result word is pending.
module pinned_lru_cache_policy_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  logic [plru_pkg::CMD_W-1:0]       command,
	input  logic [4:0]                       entry_index,
	input  logic [31:0]                      entry_bytes,
	// config channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [plru_pkg::BYTES_OUT_W-1:0] cfg_data,
	// result channel
	output logic                             result_valid,
	output logic [plru_pkg::KIND_W-1:0]      kind,
	output logic [4:0]                       result_index,
	output logic [plru_pkg::PIN_W-1:0]       pin_count,
	output logic [5:0]                       entries_resident,
	output logic [plru_pkg::BYTES_OUT_W-1:0] bytes_resident,
	output logic                             last
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_CHECK  = 5'b00100,
		S_EVICT  = 5'b01000,
		S_CLEAR  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// limits
	logic [plru_pkg::MAXE_W-1:0]      max_entries_q;
	logic [plru_pkg::BYTES_OUT_W-1:0] max_bytes_q;

	// release list and totals
	logic [plru_pkg::IDX_W-1:0]   head_q, head_d;
	logic [plru_pkg::IDX_W-1:0]   tail_q, tail_d;
	logic                         empty_q, empty_d;
	logic [plru_pkg::CNT_W-1:0]   count_q, count_d;
	logic [plru_pkg::BYTES_W-1:0] bytes_q, bytes_d;

	// latched command word
	logic [plru_pkg::CMD_W-1:0]  cmd_q;
	logic [4:0]                  idx_q;
	logic [plru_pkg::SIZE_W-1:0] size_in_q;

	// result word waiting for the limit check
	plru_pkg::kind_t            pend_kind_q, pend_kind_d;
	logic [4:0]                 pend_idx_q, pend_idx_d;
	logic [plru_pkg::PIN_W-1:0] pend_pins_q, pend_pins_d;
	logic                       enforce_q, enforce_d;

	// result word register
	logic                             out_valid_q, out_valid_d;
	plru_pkg::kind_t                  out_kind_q, out_kind_d;
	logic [4:0]                       out_idx_q, out_idx_d;
	logic [plru_pkg::PIN_W-1:0]       out_pins_q, out_pins_d;
	logic [5:0]                       out_count_q, out_count_d;
	logic [plru_pkg::BYTES_OUT_W-1:0] out_bytes_q, out_bytes_d;
	logic                             out_last_q, out_last_d;

	// entry table and shared adder
	logic [plru_pkg::IDX_W-1:0]   raddr;
	plru_pkg::tbl_wr_t            wr;
	plru_pkg::tbl_rd_t            rd;
	plru_pkg::alu_op_t            alu_op;
	logic [plru_pkg::BYTES_W-1:0] alu_a, alu_b, alu_res;
	logic                         alu_borrow;

	logic rm_en, push_en, in_range, need_evict;

	function automatic logic [plru_pkg::BYTES_OUT_W-1:0] sat_bytes(
		input logic [plru_pkg::BYTES_W-1:0] b
	);
		logic [plru_pkg::BYTES_OUT_W-1:0] r;
		if (|b[plru_pkg::BYTES_W-1:plru_pkg::BYTES_OUT_W]) begin
			r = {plru_pkg::BYTES_OUT_W{1'b1}};
		end else begin
			r = b[plru_pkg::BYTES_OUT_W-1:0];
		end
		return r;
	endfunction

	plru_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.wr     (wr),
		.rd     (rd)
	);

	plru_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign in_range  = (plru_pkg::CNT_W'(idx_q) < plru_pkg::CNT_W'(plru_pkg::NUM_ENTRIES));

	// over a limit with something left to evict; the byte compare rides on the adder
	assign need_evict = !empty_q
		&& ((plru_pkg::MAXE_W'(count_q) > max_entries_q) || alu_borrow);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		count_d     = count_q;
		bytes_d     = bytes_q;
		pend_kind_d = pend_kind_q;
		pend_idx_d  = pend_idx_q;
		pend_pins_d = pend_pins_q;
		enforce_d   = enforce_q;
		out_valid_d = 1'b0;
		out_kind_d  = out_kind_q;
		out_idx_d   = out_idx_q;
		out_pins_d  = out_pins_q;
		out_count_d = out_count_q;
		out_bytes_d = out_bytes_q;
		out_last_d  = out_last_q;
		wr          = '0;
		raddr       = plru_pkg::IDX_W'(idx_q);
		alu_op      = plru_pkg::ALU_ADD;
		alu_a       = bytes_q;
		alu_b       = {{(plru_pkg::BYTES_W-plru_pkg::SIZE_W){1'b0}}, size_in_q};
		rm_en       = 1'b0;
		push_en     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end

			S_DECODE: begin
				state_d     = S_CHECK;
				pend_idx_d  = idx_q;
				pend_pins_d = rd.pins;
				pend_kind_d = plru_pkg::KIND_ERROR;
				enforce_d   = 1'b0;
				if (cmd_q == plru_pkg::CMD_CLEAR) begin
					if (empty_q) begin
						// nothing dropped: one cleared word naming entry zero
						pend_kind_d = plru_pkg::KIND_CLEARED;
						pend_idx_d  = '0;
						pend_pins_d = '0;
					end else begin
						state_d = S_CLEAR;
					end
				end else if (!in_range) begin
					pend_pins_d = '0;
				end else if (cmd_q == plru_pkg::CMD_LOCK) begin
					if (rd.pins == plru_pkg::PIN_MAX) begin
						pend_kind_d = plru_pkg::KIND_ERROR;
					end else begin
						wr.pin_we   = 1'b1;
						wr.pin_addr = raddr;
						wr.pin_d    = rd.pins + 1'b1;
						pend_pins_d = rd.pins + 1'b1;
						if (rd.resident) begin
							pend_kind_d = plru_pkg::KIND_HIT;
							rm_en       = rd.on_list;
						end else begin
							pend_kind_d  = plru_pkg::KIND_MISS;
							enforce_d    = 1'b1;
							wr.res_we    = 1'b1;
							wr.res_addr  = raddr;
							wr.res_d     = 1'b1;
							wr.size_we   = 1'b1;
							wr.size_addr = raddr;
							wr.size_d    = size_in_q;
							count_d      = count_q + 1'b1;
							bytes_d      = alu_res;
						end
					end
				end else if (cmd_q == plru_pkg::CMD_UNLOCK) begin
					if (rd.pins == '0 || !rd.resident) begin
						pend_kind_d = plru_pkg::KIND_ERROR;
					end else begin
						wr.pin_we   = 1'b1;
						wr.pin_addr = raddr;
						wr.pin_d    = rd.pins - 1'b1;
						pend_pins_d = rd.pins - 1'b1;
						if (rd.pins != plru_pkg::PIN_W'(1)) begin
							pend_kind_d = plru_pkg::KIND_PINNED;
						end else begin
							pend_kind_d = plru_pkg::KIND_RELEASED;
							enforce_d   = 1'b1;
							push_en     = !rd.on_list;
						end
					end
				end
			end

			S_CHECK: begin
				// byte limit compare: max_bytes - total borrows when over
				alu_op      = plru_pkg::ALU_SUB;
				alu_a       = {1'b0, max_bytes_q};
				alu_b       = bytes_q;
				out_valid_d = 1'b1;
				out_kind_d  = pend_kind_q;
				out_idx_d   = pend_idx_q;
				out_pins_d  = pend_pins_q;
				out_count_d = 6'(count_q);
				out_bytes_d = sat_bytes(bytes_q);
				out_last_d  = !(enforce_q && need_evict);
				if (enforce_q && need_evict) begin
					state_d = S_EVICT;
				end else begin
					state_d = S_IDLE;
				end
			end

			S_EVICT: begin
				// drop the oldest released entry, report it after the next check
				raddr       = tail_q;
				rm_en       = 1'b1;
				wr.res_we   = 1'b1;
				wr.res_addr = tail_q;
				wr.res_d    = 1'b0;
				alu_op      = plru_pkg::ALU_SUB;
				alu_b       = {{(plru_pkg::BYTES_W-plru_pkg::SIZE_W){1'b0}}, rd.size};
				count_d     = count_q - 1'b1;
				bytes_d     = alu_res;
				pend_kind_d = plru_pkg::KIND_EVICTED;
				pend_idx_d  = 5'(tail_q);
				state_d     = S_CHECK;
			end

			S_CLEAR: begin
				// newest first, one dropped entry and one word a cycle
				raddr       = head_q;
				rm_en       = 1'b1;
				wr.res_we   = 1'b1;
				wr.res_addr = head_q;
				wr.res_d    = 1'b0;
				alu_op      = plru_pkg::ALU_SUB;
				alu_b       = {{(plru_pkg::BYTES_W-plru_pkg::SIZE_W){1'b0}}, rd.size};
				count_d     = count_q - 1'b1;
				bytes_d     = alu_res;
				out_valid_d = 1'b1;
				out_kind_d  = plru_pkg::KIND_CLEARED;
				out_idx_d   = 5'(head_q);
				out_pins_d  = '0;
				out_count_d = 6'(count_q - 1'b1);
				out_bytes_d = sat_bytes(alu_res);
				out_last_d  = (tail_q == head_q);
				if (tail_q == head_q) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// take the entry at raddr off the release list
		if (rm_en) begin
			wr.onl_we   = 1'b1;
			wr.onl_addr = raddr;
			wr.onl_d    = 1'b0;
			if (head_q == raddr && tail_q == raddr) begin
				empty_d = 1'b1;
			end else if (head_q == raddr) begin
				head_d = rd.older;
			end else if (tail_q == raddr) begin
				tail_d = rd.newer;
			end else begin
				wr.newer_we   = 1'b1;
				wr.newer_addr = rd.older;
				wr.newer_d    = rd.newer;
				wr.older_we   = 1'b1;
				wr.older_addr = rd.newer;
				wr.older_d    = rd.older;
			end
		end

		// put the entry at raddr at the most recent end
		if (push_en) begin
			wr.onl_we   = 1'b1;
			wr.onl_addr = raddr;
			wr.onl_d    = 1'b1;
			if (empty_q) begin
				head_d  = raddr;
				tail_d  = raddr;
				empty_d = 1'b0;
			end else begin
				wr.newer_we   = 1'b1;
				wr.newer_addr = head_q;
				wr.newer_d    = raddr;
				wr.older_we   = 1'b1;
				wr.older_addr = raddr;
				wr.older_d    = head_q;
				head_d        = raddr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_entries_q <= plru_pkg::MAX_ENTRIES_RST;
			max_bytes_q   <= plru_pkg::MAX_BYTES_RST;
			head_q        <= '0;
			tail_q        <= '0;
			empty_q       <= 1'b1;
			count_q       <= '0;
			bytes_q       <= '0;
			enforce_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			empty_q     <= empty_d;
			count_q     <= count_d;
			bytes_q     <= bytes_d;
			enforce_q   <= enforce_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == plru_pkg::CFG_MAX_ENTRIES) begin
					max_entries_q <= cfg_data[plru_pkg::MAXE_W-1:0];
				end else begin
					max_bytes_q <= cfg_data;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q     <= command;
			idx_q     <= entry_index;
			size_in_q <= entry_bytes;
		end
		pend_kind_q <= pend_kind_d;
		pend_idx_q  <= pend_idx_d;
		pend_pins_q <= pend_pins_d;
		out_kind_q  <= out_kind_d;
		out_idx_q   <= out_idx_d;
		out_pins_q  <= out_pins_d;
		out_count_q <= out_count_d;
		out_bytes_q <= out_bytes_d;
		out_last_q  <= out_last_d;
	end

	assign result_valid     = out_valid_q;
	assign kind             = out_kind_q;
	assign result_index     = out_idx_q;
	assign pin_count        = out_pins_q;
	assign entries_resident = out_count_q;
	assign bytes_resident   = out_bytes_q;
	assign last             = out_last_q;

	// the final word of a command leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("last word issued while sequencer still busy");

	// more words of the same command still to come
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final word issued with sequencer idle");

	// an accepted command cannot produce a word in the following cycle
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !result_valid)
		else $error("word issued straight after command accept");

	// resident count never exceeds the number of entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (entries_resident <= 6'(plru_pkg::NUM_ENTRIES)))
		else $error("resident count beyond entry count");

endmodule

@@ sv/plru_alu.sv @@
// shared byte-total adder / subtractor, also used as the byte-limit comparator
module plru_alu (
	input  plru_pkg::alu_op_t            op,
	input  logic [plru_pkg::BYTES_W-1:0] a,
	input  logic [plru_pkg::BYTES_W-1:0] b,
	output logic [plru_pkg::BYTES_W-1:0] res,
	output logic                         borrow
);

	logic [plru_pkg::BYTES_W:0] full;

	always_comb begin
		if (op == plru_pkg::ALU_SUB) begin
			full = {1'b0, a} - {1'b0, b};
		end else begin
			full = {1'b0, a} + {1'b0, b};
		end
	end

	assign res    = full[plru_pkg::BYTES_W-1:0];
	// carry out on add, borrow on subtract
	assign borrow = full[plru_pkg::BYTES_W];

endmodule

@@ sv/plru_table.sv @@
// per-entry state: residency, pin counts, sizes and release-list links
module plru_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [plru_pkg::IDX_W-1:0] raddr,
	input  plru_pkg::tbl_wr_t          wr,
	output plru_pkg::tbl_rd_t          rd
);

	logic                        resident_q [plru_pkg::NUM_ENTRIES];
	logic [plru_pkg::PIN_W-1:0]  pin_q      [plru_pkg::NUM_ENTRIES];
	logic                        onl_q      [plru_pkg::NUM_ENTRIES];
	logic [plru_pkg::SIZE_W-1:0] size_q     [plru_pkg::NUM_ENTRIES];
	logic [plru_pkg::IDX_W-1:0]  newer_q    [plru_pkg::NUM_ENTRIES];
	logic [plru_pkg::IDX_W-1:0]  older_q    [plru_pkg::NUM_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < plru_pkg::NUM_ENTRIES; i++) begin
				resident_q[i] <= 1'b0;
				pin_q[i]      <= '0;
				onl_q[i]      <= 1'b0;
			end
		end else begin
			if (wr.res_we) begin
				resident_q[wr.res_addr] <= wr.res_d;
			end
			if (wr.pin_we) begin
				pin_q[wr.pin_addr] <= wr.pin_d;
			end
			if (wr.onl_we) begin
				onl_q[wr.onl_addr] <= wr.onl_d;
			end
		end
	end

	// sizes and links only read after being written
	always_ff @(posedge clk) begin
		if (wr.size_we) begin
			size_q[wr.size_addr] <= wr.size_d;
		end
		if (wr.newer_we) begin
			newer_q[wr.newer_addr] <= wr.newer_d;
		end
		if (wr.older_we) begin
			older_q[wr.older_addr] <= wr.older_d;
		end
	end

	assign rd.resident = resident_q[raddr];
	assign rd.pins     = pin_q[raddr];
	assign rd.size     = size_q[raddr];
	assign rd.on_list  = onl_q[raddr];
	assign rd.newer    = newer_q[raddr];
	assign rd.older    = older_q[raddr];

endmodule
